// File: src/tcc_pkg.sv
// Shared types and constants of the text console cursor unit.
// No dependencies; every other file of the block imports this package.
package tcc_pkg;

	localparam int COL_W     = 8;   // cursor column and cell_column width
	localparam int ROW_W     = 7;   // cursor row and cell_row width
	localparam int COLS_W    = 9;   // columns register width
	localparam int ROWS_W    = 8;   // rows register width
	localparam int CHAR_W    = 8;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 4;
	localparam int CNT_W     = 4;   // tab space counter, counts 0 .. TAB_STOP

	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_MAX_ROWS    = 128;
	localparam int COL_HW_LIM      = 256;
	localparam int ROW_HW_LIM      = 128;

	localparam logic [COLS_W-1:0] COLUMNS_RST = 9'd80;
	localparam logic [ROWS_W-1:0] ROWS_RST    = 8'd25;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam int                TAB_STOP     = 8;
	localparam int                TAB_BITS     = $clog2(TAB_STOP);

	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [1:0] REG_ENABLED = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;

	typedef enum logic [1:0] {
		KIND_DRAW   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_GLYPH,
		ST_SCROLL
	} state_t;

	typedef struct packed {
		logic              enabled;
		logic [COLS_W-1:0] columns;
		logic [ROWS_W-1:0] rows;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic do_clear;
		logic do_newline;
		logic do_backspace;
		logic do_glyph;
		logic do_scroll;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_newline;
		logic is_backspace;
		logic nl_scroll;
		logic adv_scroll;
		logic adv_more;
		logic cur_more;
		logic out_free;
	} status_t;

endpackage

// File: src/tcc_if.sv
// Channel interfaces of the text console cursor unit: input items and cell commands.
// Depends on tcc_pkg for field widths.
interface tcc_in_if;
	import tcc_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, op, char_code, input ready);
	modport sink   (input valid, op, char_code, output ready);
endinterface

interface tcc_out_if;
	import tcc_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [7:0]       glyph;
	logic [COL_W-1:0] cell_column;
	logic [ROW_W-1:0] cell_row;
	logic             last;

	modport source (output valid, kind, glyph, cell_column, cell_row, last, input ready);
	modport sink   (input valid, kind, glyph, cell_column, cell_row, last, output ready);
endinterface

// File: src/tcc_regs.sv
// APB configuration registers: enabled, columns, rows.
// Depends on tcc_pkg.
module tcc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcc_pkg::DATA_W-1:0]    pwdata,
	output logic [tcc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output tcc_pkg::cfg_t                 cfg
);
	import tcc_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.columns <= COLUMNS_RST;
			cfg_q.rows    <= ROWS_RST;
		end else if (wr) begin
			unique case (idx)
				REG_ENABLED: cfg_q.enabled <= pwdata[0];
				REG_COLUMNS: cfg_q.columns <= pwdata[COLS_W-1:0];
				REG_ROWS:    cfg_q.rows    <= pwdata[ROWS_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_ENABLED: prdata = {{(DATA_W-1){1'b0}}, cfg_q.enabled};
			REG_COLUMNS: prdata = {{(DATA_W-COLS_W){1'b0}}, cfg_q.columns};
			REG_ROWS:    prdata = {{(DATA_W-ROWS_W){1'b0}}, cfg_q.rows};
			default:     prdata = '0;
		endcase
	end

endmodule

// File: src/tcc_ctrl.sv
// Controller state machine: sequences one input item into cell commands.
// Depends on tcc_pkg; drives tcc_dp through cmd_t and reads its status_t.
module tcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              enabled,
	input  tcc_pkg::status_t  st,
	output logic              in_ready,
	output tcc_pkg::cmd_t     cmd
);
	import tcc_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// Drop items while disabled.
				if (in_valid && enabled) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (st.is_clear) begin
					if (st.out_free) begin
						cmd.do_clear = 1'b1;
						cmd.last     = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end else if (st.is_newline) begin
					cmd.do_newline = 1'b1;
					state_nxt      = st.nl_scroll ? ST_SCROLL : ST_IDLE;
				end else if (st.is_backspace) begin
					if (st.out_free) begin
						cmd.do_backspace = 1'b1;
						cmd.last         = 1'b1;
						state_nxt        = ST_IDLE;
					end
				end else begin
					state_nxt = ST_GLYPH;
				end
			end
			ST_GLYPH: begin
				if (st.out_free) begin
					cmd.do_glyph = 1'b1;
					cmd.last     = !st.adv_scroll && !st.adv_more;
					if (st.adv_scroll) begin
						state_nxt = ST_SCROLL;
					end else if (st.adv_more) begin
						state_nxt = ST_GLYPH;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SCROLL: begin
				if (st.out_free) begin
					cmd.do_scroll = 1'b1;
					cmd.last      = !st.cur_more;
					state_nxt     = st.cur_more ? ST_GLYPH : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// File: src/tcc_dp.sv
// Datapath: cursor registers, geometry clamp, next-cell arithmetic, output register.
// Depends on tcc_pkg; commanded by tcc_ctrl.
module tcc_dp #(
	parameter int MAX_COLUMNS = tcc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcc_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcc_pkg::cfg_t                 cfg,
	input  tcc_pkg::cmd_t                 cmd,
	input  logic                          in_op,
	input  logic [tcc_pkg::CHAR_W-1:0]    in_char,
	input  logic                          out_ready,
	output tcc_pkg::status_t              st,
	output logic                          out_valid,
	output logic [1:0]                    out_kind,
	output logic [7:0]                    out_glyph,
	output logic [tcc_pkg::COL_W-1:0]     out_column,
	output logic [tcc_pkg::ROW_W-1:0]     out_row,
	output logic                          out_last
);
	import tcc_pkg::*;

	localparam int COL_LIM = (MAX_COLUMNS < COL_HW_LIM) ? MAX_COLUMNS : COL_HW_LIM;
	localparam int ROW_LIM = (MAX_ROWS < ROW_HW_LIM) ? MAX_ROWS : ROW_HW_LIM;
	localparam logic [COLS_W-1:0] COL_LIM_V = COLS_W'(COL_LIM);
	localparam logic [ROWS_W-1:0] ROW_LIM_V = ROWS_W'(ROW_LIM);
	localparam logic [ROWS_W-1:0] ROW_MIN_V = ROWS_W'(2);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              op_q;
	logic [CHAR_W-1:0] char_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              ov_q;
	kind_t             kind_q;
	logic [7:0]        glyph_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;
	logic              olast_q;

	logic [COLS_W-1:0] ncols;
	logic [ROWS_W-1:0] nrows;
	logic [COLS_W-1:0] col_inc;
	logic [ROWS_W-1:0] row_inc;
	logic              wrap;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;
	logic [CNT_W-1:0]  cnt_inc;
	logic              is_tab;
	logic [COL_W-1:0]  bs_col;
	logic [ROW_W-1:0]  bs_row;
	logic [COL_W-1:0]  sat_col;
	logic [ROW_W-1:0]  sat_row;
	logic [7:0]        glyph_sel;
	logic              emit;

	// Clamp the geometry to what the cursor registers can address.
	always_comb begin
		if (cfg.columns == '0) ncols = COLS_W'(1);
		else if (cfg.columns > COL_LIM_V) ncols = COL_LIM_V;
		else ncols = cfg.columns;
		if (cfg.rows < ROW_MIN_V) nrows = ROW_MIN_V;
		else if (cfg.rows > ROW_LIM_V) nrows = ROW_LIM_V;
		else nrows = cfg.rows;
	end

	always_comb begin
		sat_col = ({1'b0, col_q} >= ncols) ? COL_W'(ncols - COLS_W'(1)) : col_q;
		sat_row = ({1'b0, row_q} >= nrows) ? ROW_W'(nrows - ROWS_W'(1)) : row_q;

		col_inc  = {1'b0, col_q} + COLS_W'(1);
		row_inc  = {1'b0, row_q} + ROWS_W'(1);
		wrap     = col_inc >= ncols;
		col_next = wrap ? '0 : col_inc[COL_W-1:0];
		st.adv_scroll = wrap && (row_inc >= nrows);
		row_next = (wrap && !st.adv_scroll) ? row_inc[ROW_W-1:0] : row_q;
		cnt_inc  = cnt_q + CNT_W'(1);

		is_tab   = !op_q && (char_q == CH_TAB);
		st.adv_more = is_tab && (col_next[TAB_BITS-1:0] != '0) && (cnt_inc < CNT_W'(TAB_STOP));
		st.cur_more = is_tab && (col_q[TAB_BITS-1:0] != '0) && (cnt_q < CNT_W'(TAB_STOP));

		st.is_clear     = (op_q == OP_CLEAR);
		st.is_newline   = (char_q == CH_NEWLINE);
		st.is_backspace = (char_q == CH_BACKSPACE);
		st.nl_scroll    = row_inc >= nrows;
		st.out_free     = !ov_q || out_ready;

		// Step back; wrap to the last column of the previous row, stick at home.
		if (col_q != '0) begin
			bs_col = col_q - COL_W'(1);
			bs_row = row_q;
		end else if (row_q != '0) begin
			bs_col = COL_W'(ncols - COLS_W'(1));
			bs_row = row_q - ROW_W'(1);
		end else begin
			bs_col = col_q;
			bs_row = row_q;
		end

		glyph_sel = is_tab ? CH_SPACE : char_q;
		emit = cmd.do_clear || cmd.do_backspace || cmd.do_glyph || cmd.do_scroll;
	end

	// Cursor and item registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.capture) begin
			col_q <= sat_col;
			row_q <= sat_row;
		end else if (cmd.do_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.do_newline) begin
			col_q <= '0;
			if (!st.nl_scroll) row_q <= row_inc[ROW_W-1:0];
		end else if (cmd.do_backspace) begin
			col_q <= bs_col;
			row_q <= bs_row;
		end else if (cmd.do_glyph) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			char_q <= in_char;
			cnt_q  <= '0;
		end else if (cmd.do_glyph) begin
			cnt_q  <= cnt_inc;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			olast_q <= cmd.last;
			if (cmd.do_glyph || cmd.do_backspace) begin
				kind_q  <= KIND_DRAW;
				glyph_q <= cmd.do_glyph ? glyph_sel : CH_SPACE;
				ocol_q  <= cmd.do_glyph ? col_q : bs_col;
				orow_q  <= cmd.do_glyph ? row_q : bs_row;
			end else begin
				kind_q  <= cmd.do_clear ? KIND_CLEAR : KIND_SCROLL;
				glyph_q <= '0;
				ocol_q  <= '0;
				orow_q  <= '0;
			end
		end
	end

	assign out_valid  = ov_q;
	assign out_kind   = kind_q;
	assign out_glyph  = glyph_q;
	assign out_column = ocol_q;
	assign out_row    = orow_q;
	assign out_last   = olast_q;

endmodule

// File: src/text_console_cursor_unit.sv
// Top level of the text console cursor unit: registers, controller and datapath.
// Depends on tcc_pkg, tcc_if, tcc_regs, tcc_ctrl and tcc_dp.
//
// Usage:
//   char_ch carries input items (op, char_code); a transaction completes when
//   valid and ready are both high at a rising clk edge. cell_ch carries cell
//   commands (kind, glyph, cell_column, cell_row, last) under the same rule;
//   last marks the final command caused by one input item.
//   The APB port writes enabled (0x0), columns (0x4) and rows (0x8); pready is
//   always high. Write configuration only while the unit is idle.
// Timing:
//   One item at a time. After its transaction an item passes through the
//   dispatch state; clear and backspace issue their one command from dispatch,
//   newline issues none there, and every other command comes from the glyph or
//   scroll state. A tab issues at most eight spaces and one scroll, since a
//   wrap ends it. A disabled unit takes an item every cycle and drops it. The
//   single-entry output register sets the pace: each command waits there until
//   cell_ch takes it, and the controller holds while it is full.
// Reset:
//   arst_n clears the cursor to home, drops any pending command and loads
//   enabled 0, columns 80, rows 25.
module text_console_cursor_unit #(
	parameter int MAX_COLUMNS = tcc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = tcc_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tcc_in_if.sink                        char_ch,
	tcc_out_if.source                     cell_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcc_pkg::DATA_W-1:0]    pwdata,
	output logic [tcc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import tcc_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;
	logic    in_ready;

	tcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequence each accepted item; ready only between items.
	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (char_ch.valid),
		.enabled  (cfg.enabled),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	assign char_ch.ready = in_ready;

	// Hold the cursor and the pending cell command.
	tcc_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.in_op      (char_ch.op),
		.in_char    (char_ch.char_code),
		.out_ready  (cell_ch.ready),
		.st         (st),
		.out_valid  (cell_ch.valid),
		.out_kind   (cell_ch.kind),
		.out_glyph  (cell_ch.glyph),
		.out_column (cell_ch.cell_column),
		.out_row    (cell_ch.cell_row),
		.out_last   (cell_ch.last)
	);

endmodule

// File: src/tcc_checker.sv
// Port-level checker for the text console cursor unit, bound to the top level.
// Depends on tcc_pkg and text_console_cursor_unit.
module tcc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                out_kind,
	input logic [7:0]                out_glyph,
	input logic [tcc_pkg::COL_W-1:0] out_column,
	input logic [tcc_pkg::ROW_W-1:0] out_row,
	input logic                      out_last
);
	import tcc_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("cell command dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_glyph)
			&& $stable(out_column) && $stable(out_row) && $stable(out_last))
		else $error("cell command changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_DRAW) || (out_kind == KIND_SCROLL)
			|| (out_kind == KIND_CLEAR))
		else $error("undefined cell command kind");

	a_nondraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_DRAW) |->
			out_glyph == '0 && out_column == '0 && out_row == '0)
		else $error("scroll or clear with nonzero cell fields");

	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_CLEAR) |-> out_last)
		else $error("clear not marked last");

endmodule

bind text_console_cursor_unit tcc_checker u_tcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (cell_ch.valid),
	.out_ready  (cell_ch.ready),
	.out_kind   (cell_ch.kind),
	.out_glyph  (cell_ch.glyph),
	.out_column (cell_ch.cell_column),
	.out_row    (cell_ch.cell_row),
	.out_last   (cell_ch.last)
);

// File: tb/sv/tcc_cell_checker.sv
// Cell command checker for the text console cursor unit: watches the APB port and both
// channels, predicts every cell command and compares it with what the unit sends.
// Depends on tcc_pkg and the tcc_in_if / tcc_out_if channel interfaces.
module tcc_cell_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	tcc_in_if                           char_mon,
	tcc_out_if                          cell_mon,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [tcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
	output int                          fail_count,
	output int                          open_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcc_pkg::*;

	localparam int COL_LIMIT = (DEF_MAX_COLUMNS < COL_HW_LIM) ? DEF_MAX_COLUMNS : COL_HW_LIM;
	localparam int ROW_LIMIT = (DEF_MAX_ROWS < ROW_HW_LIM) ? DEF_MAX_ROWS : ROW_HW_LIM;
	localparam int CMD_MAX   = 16;

	typedef struct {
		kind_t             kind;
		logic [7:0]        glyph;
		logic [COL_W-1:0]  cell_column;
		logic [ROW_W-1:0]  cell_row;
		logic              last;
	} cell_cmd_t;

	logic              cfg_enabled;
	logic [COLS_W-1:0] cfg_columns;
	logic [ROWS_W-1:0] cfg_rows;
	int unsigned       cur_col, cur_row;
	int unsigned       n_cols, n_rows;
	cell_cmd_t         new_cmds[CMD_MAX];
	int                new_n;
	cell_cmd_t         pending_cells[$];

	function automatic void add_cmd(kind_t k, logic [7:0] g, int unsigned c, int unsigned r);
		if (new_n < CMD_MAX) begin
			new_cmds[new_n].kind        = k;
			new_cmds[new_n].glyph       = g;
			new_cmds[new_n].cell_column = COL_W'(c);
			new_cmds[new_n].cell_row    = ROW_W'(r);
			new_cmds[new_n].last        = 1'b0;
			new_n++;
		end
	endfunction

	function automatic void scroll_if_below();
		if (cur_row >= n_rows) begin
			add_cmd(KIND_SCROLL, 8'd0, 0, 0);
			cur_row = n_rows - 1;
		end
	endfunction

	function automatic void draw_and_advance(logic [7:0] g);
		add_cmd(KIND_DRAW, g, cur_col, cur_row);
		cur_col++;
		if (cur_col >= n_cols) begin
			cur_col = 0;
			cur_row++;
		end
		scroll_if_below();
	endfunction

	// Work out the cell commands of one character transaction and queue them.
	function automatic void predict_cells(logic op, logic [CHAR_W-1:0] code);
		int spaces;
		new_n = 0;
		if (!cfg_enabled)
			return;
		n_cols = (cfg_columns < 1) ? 1 : ((cfg_columns > COL_LIMIT) ? COL_LIMIT : cfg_columns);
		n_rows = (cfg_rows < 2) ? 2 : ((cfg_rows > ROW_LIMIT) ? ROW_LIMIT : cfg_rows);
		if (cur_col >= n_cols) cur_col = n_cols - 1;
		if (cur_row >= n_rows) cur_row = n_rows - 1;

		if (op == OP_CLEAR) begin
			add_cmd(KIND_CLEAR, 8'd0, 0, 0);
			cur_col = 0;
			cur_row = 0;
		end else if (code == CH_NEWLINE) begin
			cur_col = 0;
			cur_row++;
			scroll_if_below();
		end else if (code == CH_TAB) begin
			spaces = 0;
			do begin
				draw_and_advance(CH_SPACE);
				spaces++;
			end while ((cur_col % TAB_STOP) != 0 && spaces < TAB_STOP);
		end else if (code == CH_BACKSPACE) begin
			if (cur_col > 0) begin
				cur_col--;
			end else if (cur_row > 0) begin
				cur_row--;
				cur_col = n_cols - 1;
			end
			add_cmd(KIND_DRAW, CH_SPACE, cur_col, cur_row);
		end else begin
			draw_and_advance(code);
		end

		if (new_n > 0)
			new_cmds[new_n-1].last = 1'b1;
		for (int i = 0; i < new_n; i++)
			pending_cells.push_back(new_cmds[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_cmd_t exp_cmd;
		if (!arst_n) begin
			cfg_enabled = 1'b0;
			cfg_columns = COLUMNS_RST;
			cfg_rows    = ROWS_RST;
			cur_col     = 0;
			cur_row     = 0;
			new_n       = 0;
			fail_count  = 0;
			pending_cells.delete();
		end else begin
			// compare first: a command leaving now belongs to an earlier transaction
			if (cell_mon.valid && cell_mon.ready) begin
				if (pending_cells.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] unexpected cell command: ", $realtime,
							"kind %0d glyph 0x%02h col %0d row %0d last %0b",
							cell_mon.kind, cell_mon.glyph, cell_mon.cell_column,
							cell_mon.cell_row, cell_mon.last);
				end else begin
					exp_cmd = pending_cells.pop_front();
					if (cell_mon.kind !== exp_cmd.kind || cell_mon.glyph !== exp_cmd.glyph ||
					    cell_mon.cell_column !== exp_cmd.cell_column ||
					    cell_mon.cell_row !== exp_cmd.cell_row ||
					    cell_mon.last !== exp_cmd.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("[%0t] cell command mismatch: ", $realtime,
								"expected kind %0d glyph 0x%02h col %0d row %0d last %0b",
								exp_cmd.kind, exp_cmd.glyph, exp_cmd.cell_column,
								exp_cmd.cell_row, exp_cmd.last,
								", got kind %0d glyph 0x%02h col %0d row %0d last %0b",
								cell_mon.kind, cell_mon.glyph, cell_mon.cell_column,
								cell_mon.cell_row, cell_mon.last);
					end
				end
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ENABLED: cfg_enabled = pwdata[0];
					REG_COLUMNS: cfg_columns = pwdata[COLS_W-1:0];
					REG_ROWS:    cfg_rows    = pwdata[ROWS_W-1:0];
					default: ;
				endcase
			end

			if (char_mon.valid && char_mon.ready)
				predict_cells(char_mon.op, char_mon.char_code);
		end
		open_count = pending_cells.size();
	end

endmodule

// File: tb/sv/tb_text_console_cursor_unit.sv
// Top of the text console cursor unit testbench: clock, reset, stimulus and verdict.
// Depends on tcc_pkg, tcc_if, the unit itself and tcc_cell_checker for the comparison.
module tb_text_console_cursor_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tcc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	int                 failures;
	int                 open_cells;
	bit                 calm;        // no idling on either side once set
	int                 stall_left;

	tcc_in_if  char_ch ();
	tcc_out_if cell_ch ();

	always #4 clk = ~clk;

	text_console_cursor_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.cell_ch (cell_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tcc_cell_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_mon   (char_ch),
		.cell_mon   (cell_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (failures),
		.open_count (open_cells)
	);

	// Stall the cell channel in random bursts; hold ready high once calm.
	// One assignment per falling edge keeps ready free of same-step races.
	initial begin
		cell_ch.ready = 1'b0;
		stall_left    = 0;
		forever begin
			@(negedge clk);
			if (calm || !arst_n) begin
				cell_ch.ready <= arst_n;
				stall_left = 0;
			end else if (stall_left > 0) begin
				cell_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				cell_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				cell_ch.ready <= 1'b1;
			end
		end
	end

	// Drive one character transaction, with an optional idle burst in front.
	// Leave valid high afterwards so back-to-back items need no second assignment.
	task automatic send_char(input logic op, input logic [CHAR_W-1:0] code);
		if (!calm && $urandom_range(0, 3) == 0) begin
			char_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		char_ch.valid     <= 1'b1;
		char_ch.op        <= op;
		char_ch.char_code <= code;
		do @(posedge clk); while (!char_ch.ready);
		@(negedge clk);
	endtask

	// A mix of control codes and random byte values, with the odd clear request.
	task automatic send_random_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			send_char(OP_CLEAR, CHAR_W'($urandom_range(0, 255)));
		else if (pick < 24)
			send_char(OP_PUT, CH_NEWLINE);
		else if (pick < 40)
			send_char(OP_PUT, CH_TAB);
		else if (pick < 54)
			send_char(OP_PUT, CH_BACKSPACE);
		else
			send_char(OP_PUT, CHAR_W'($urandom_range(0, 255)));
	endtask

	// Drop valid, wait out every predicted command, then give a newline without
	// scroll (which leaves no trace on the cell channel) time to finish.
	task automatic settle();
		char_ch.valid <= 1'b0;
		while (open_cells != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes it at the edge that ends the access cycle.
	task automatic reg_write(input logic [1:0] idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_geometry(input int unsigned cols, input int unsigned rws);
		reg_write(REG_COLUMNS, cols);
		reg_write(REG_ROWS, rws);
	endtask

	initial begin
		int unsigned geo_cols[6] = '{256, 0, 511, 8, 9, 1};
		int unsigned geo_rows[6] = '{128, 0, 255, 3, 2, 200};

		calm              = 1'b0;
		arst_n            = 1'b0;
		char_ch.valid     = 1'b0;
		char_ch.op        = OP_PUT;
		char_ch.char_code = '0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;

		// hold reset, then release it away from the sampling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The unit comes up disabled: these transactions, the clear among them,
		// must leave no commands and keep the cursor at home.
		send_char(OP_PUT, 8'h58);
		send_char(OP_CLEAR, 8'h00);
		send_char(OP_PUT, CH_TAB);
		settle();
		reg_write(REG_ENABLED, 1);

		// Default 80 x 25 screen: glyph extremes, every control code, tab from a
		// column off the tab stop, backspace wrapping to the previous row, tab at
		// the last column, and backspace at the home cell.
		send_char(OP_CLEAR, 8'hFF);
		send_char(OP_PUT, 8'h00);
		send_char(OP_PUT, 8'hFF);
		send_char(OP_PUT, 8'h41);
		send_char(OP_PUT, CH_TAB);
		send_char(OP_PUT, CH_BACKSPACE);
		send_char(OP_PUT, CH_NEWLINE);
		send_char(OP_PUT, CH_NEWLINE);
		send_char(OP_PUT, 8'h42);
		send_char(OP_PUT, CH_BACKSPACE);
		send_char(OP_PUT, CH_BACKSPACE);
		send_char(OP_PUT, CH_TAB);
		send_char(OP_CLEAR, 8'h00);
		send_char(OP_PUT, CH_BACKSPACE);
		send_char(OP_PUT, CH_NEWLINE);
		send_char(OP_PUT, CH_NEWLINE);
		send_char(OP_PUT, CH_NEWLINE);
		send_char(OP_PUT, 8'h43);
		send_char(OP_PUT, 8'h44);
		settle();

		// Shrink to the smallest screen with the cursor outside it: the cursor
		// must clamp first, then every step wraps and scrolls.
		set_geometry(1, 2);
		send_char(OP_PUT, 8'h45);
		send_char(OP_PUT, CH_TAB);
		send_char(OP_PUT, CH_NEWLINE);

		// Random phases, each on its own geometry: full size, out-of-range
		// values that must saturate, tiny screens, and a disabled stretch.
		for (int p = 0; p < 8; p++) begin
			settle();
			calm = (p == 7);
			if (p == 4) begin
				reg_write(REG_ENABLED, 0);
				repeat (10) send_random_char();
				settle();
				reg_write(REG_ENABLED, 1);
			end
			if (p < 6)
				set_geometry(geo_cols[p], geo_rows[p]);
			else if (p == 6)
				set_geometry($urandom_range(1, 40), $urandom_range(2, 10));
			else
				set_geometry($urandom_range(0, 511), $urandom_range(0, 255));
			repeat (9) send_random_char();
		end

		// drain the last commands, then give stray commands time to show up
		settle();
		repeat (10) @(negedge clk);
		if (failures == 0 && open_cells == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Abort a hung run; a correct one ends far sooner.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
src/tcc_pkg.sv
src/tcc_if.sv
src/tcc_regs.sv
src/tcc_ctrl.sv
src/tcc_dp.sv
src/text_console_cursor_unit.sv
src/tcc_checker.sv
tb/sv/tcc_cell_checker.sv
tb/sv/tb_text_console_cursor_unit.sv
